>>> rtl/quadrature_pid_position_drive_assert.svh
// Assertion helpers for the drive's top-level RTL.
// Each macro samples on the rising edge of clock and is ignored while reset is high.
`ifndef QUADRATURE_PID_POSITION_DRIVE_ASSERT_SVH
`define QUADRATURE_PID_POSITION_DRIVE_ASSERT_SVH

// Same-cycle implication.
`define QPPD_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define QPPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/qppd_pkg.sv
package qppd_pkg;

   // request kinds carried on req_tuser
   localparam logic [1:0] REQ_ENC  = 2'd0;
   localparam logic [1:0] REQ_TICK = 2'd1;
   localparam logic [1:0] REQ_ZERO = 2'd2;

   // register indexes on the csr port
   localparam logic [1:0] CSR_GOAL = 2'd0;
   localparam logic [1:0] CSR_KP   = 2'd1;
   localparam logic [1:0] CSR_KI   = 2'd2;
   localparam logic [1:0] CSR_KD   = 2'd3;

   localparam logic [31:0] GOAL_RST = 32'd0;
   localparam logic [15:0] KP_RST   = 16'd4096;
   localparam logic [15:0] KI_RST   = 16'd41;
   localparam logic [15:0] KD_RST   = 16'd4;

   // quadrature step codes
   localparam logic [1:0] QS_HOLD = 2'd0;
   localparam logic [1:0] QS_UP   = 2'd1;
   localparam logic [1:0] QS_DOWN = 2'd2;

   // stage one payload: state snapshot and PID operands
   typedef struct packed {
      logic        tick;
      logic [31:0] count;
      logic [31:0] err;
      logic [31:0] integ;
      logic [32:0] diff;
   } qppd_stage1_type;

   // index is {previous A/B pair, new A/B pair}
   function automatic logic [1:0] qppd_quad_step(input logic [3:0] idx);
      logic [1:0] code;
      unique case (idx)
         4'b1110, 4'b0111, 4'b0001, 4'b1000: code = QS_UP;
         4'b1101, 4'b0100, 4'b0010, 4'b1011: code = QS_DOWN;
         default:                            code = QS_HOLD;
      endcase
      return code;
   endfunction

endpackage

>>> rtl/quadrature_pid_position_drive.sv
// Channel  Ports                         Width  Contents (lowest bit first)
// req      req_tvalid/tready/tdata/tuser  8+2   tdata: chan_a, chan_b; tuser: req_type
// rsp      rsp_tvalid/tready/tdata        48    tdata: position, duty, forward
// csr      csr_wr_en/addr/wdata           2+32  goal, kp, ki, kd by index
//
// One request is taken per cycle while req_tready is high; its response is offered
// once it has passed the three registered stages (state update, gain
// multipliers, sum and clamp).
// The three 32x16 gain products set the length of the middle stage.
// Reset is synchronous: counts, PID state and duty clear, forward sets, goal and gains reload.
// A stalled response holds the output register; earlier stages keep filling
// bubbles, so req_tready drops only once all three stages hold an item.

`include "quadrature_pid_position_drive_assert.svh"

module quadrature_pid_position_drive
   import qppd_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 12,
   parameter int DUTY_MAX       = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] chan_a, [1] chan_b, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] position, [39:32] duty, [40] forward
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam int TERM_W = 48 - GAIN_FRAC_BITS;

   // configuration registers
   logic [31:0] goal_ff;
   logic [15:0] kp_ff, ki_ff, kd_ff;

   // pipeline control
   logic s1_vld_ff, s2_vld_ff, out_vld_ff;
   logic load1, load2, load_out;
   logic accept;

   qppd_stage1_type s1_stage;

   logic signed [TERM_W:0] p_term, i_term, d_term;
   logic [31:0] s2_count_ff;
   logic        s2_tick_ff;
   logic [31:0] pos_ff;
   logic [7:0]  duty;
   logic        forward;

   // take the csr write whenever enabled; the user must issue it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_ff <= GOAL_RST;
         kp_ff   <= KP_RST;
         ki_ff   <= KI_RST;
         kd_ff   <= KD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_GOAL: goal_ff <= csr_wdata;
            CSR_KP:   kp_ff   <= csr_wdata[15:0];
            CSR_KI:   ki_ff   <= csr_wdata[15:0];
            CSR_KD:   kd_ff   <= csr_wdata[15:0];
         endcase
      end
   end

   // advance a stage when the one after it is empty or advancing
   assign load_out   = ~out_vld_ff | rsp_tready;
   assign load2      = ~s2_vld_ff | load_out;
   assign load1      = ~s1_vld_ff | load2;
   assign req_tready = load1;
   assign accept     = req_tvalid & load1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (load1) begin
            s1_vld_ff <= req_tvalid;
         end
         if (load2) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (load_out) begin
            out_vld_ff <= s2_vld_ff;
         end
      end
   end

   // stage one: encoder count, error, integral and derivative difference
   qppd_state u_state (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .load     (load1),
      .req_type (req_tuser),
      .chan_a   (req_tdata[0]),
      .chan_b   (req_tdata[1]),
      .goal     (goal_ff),
      .stage_ff (s1_stage)
   );

   // stage two: the three gain products
   qppd_gain #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_gain_p (
      .clock   (clock),
      .load    (load2),
      .gain    (kp_ff),
      .operand ({s1_stage.err[31], s1_stage.err}),
      .term_ff (p_term)
   );

   qppd_gain #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_gain_i (
      .clock   (clock),
      .load    (load2),
      .gain    (ki_ff),
      .operand ({s1_stage.integ[31], s1_stage.integ}),
      .term_ff (i_term)
   );

   qppd_gain #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_gain_d (
      .clock   (clock),
      .load    (load2),
      .gain    (kd_ff),
      .operand (s1_stage.diff),
      .term_ff (d_term)
   );

   // carry position and request kind alongside the products
   always_ff @(posedge clock) begin
      if (load2) begin
         s2_count_ff <= s1_stage.count;
         s2_tick_ff  <= s1_stage.tick;
      end
   end

   // stage three: sum, direction and clamped duty; latched only by a tick
   qppd_mix #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .DUTY_MAX       (DUTY_MAX)
   ) u_mix (
      .clock   (clock),
      .reset   (reset),
      .update  (load_out & s2_vld_ff & s2_tick_ff),
      .p_term  (p_term),
      .i_term  (i_term),
      .d_term  (d_term),
      .duty_ff (duty),
      .fwd_ff  (forward)
   );

   always_ff @(posedge clock) begin
      if (load_out) begin
         pos_ff <= s2_count_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, forward, duty, pos_ff};

   `QPPD_ASSERT_IMPLIES(a_open_when_drained, !out_vld_ff, req_tready, "input closed with output empty")
   `QPPD_ASSERT_IMPLIES(a_stall_when_full, s1_vld_ff && s2_vld_ff && out_vld_ff && !rsp_tready, !req_tready, "input open with pipe full")
   `QPPD_ASSERT_NEXT(a_zero_clears, accept && (req_tuser == REQ_ZERO), s1_stage.count == 32'd0, "zero request left a count")

endmodule

>>> rtl/qppd_state.sv
module qppd_state
   import qppd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic            load,
   input  logic [1:0]      req_type,
   input  logic            chan_a,
   input  logic            chan_b,
   input  logic [31:0]     goal,
   output qppd_stage1_type stage_ff
);

   logic [1:0]  last_pair_ff, last_pair_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] integ_ff, integ_in;
   logic [31:0] prev_err_ff, prev_err_in;

   logic [1:0]  pair;
   logic [1:0]  step;
   logic        tick;
   logic [32:0] goal_diff;
   logic [31:0] err;
   logic [32:0] integ_sum;
   logic [31:0] integ_new;
   logic [32:0] diff;

   function automatic logic [31:0] sat32(input logic [32:0] v);
      logic [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   assign pair      = {chan_a, chan_b};
   assign step      = qppd_quad_step({last_pair_ff, pair});
   assign tick      = (req_type == REQ_TICK);
   assign goal_diff = {goal[31], goal} - {count_ff[31], count_ff};
   assign err       = sat32(goal_diff);
   assign integ_sum = {integ_ff[31], integ_ff} + {err[31], err};
   assign integ_new = sat32(integ_sum);
   assign diff      = {err[31], err} - {prev_err_ff[31], prev_err_ff};

   always_comb begin
      count_in     = count_ff;
      last_pair_in = last_pair_ff;
      integ_in     = integ_ff;
      prev_err_in  = prev_err_ff;
      unique case (req_type)
         REQ_ENC: begin
            last_pair_in = pair;
            priority if (step == QS_UP) begin
               count_in = count_ff + 32'd1;
            end else if (step == QS_DOWN) begin
               count_in = count_ff - 32'd1;
            end
         end
         REQ_TICK: begin
            integ_in    = integ_new;
            prev_err_in = err;
         end
         REQ_ZERO: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pair_ff <= '0;
         count_ff     <= '0;
         integ_ff     <= '0;
         prev_err_ff  <= '0;
      end else if (accept) begin
         last_pair_ff <= last_pair_in;
         count_ff     <= count_in;
         integ_ff     <= integ_in;
         prev_err_ff  <= prev_err_in;
      end
   end

   // operands for the gain stage; valid is tracked by the caller
   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff.tick  <= tick;
         stage_ff.count <= count_in;
         stage_ff.err   <= err;
         stage_ff.integ <= integ_new;
         stage_ff.diff  <= diff;
      end
   end

endmodule

>>> rtl/qppd_gain.sv
module qppd_gain #(
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic                               clock,
   input  logic                               load,
   input  logic [15:0]                        gain,
   input  logic [32:0]                        operand,
   output logic signed [48-GAIN_FRAC_BITS:0]  term_ff
);

   localparam int TERM_W = 48 - GAIN_FRAC_BITS;

   logic                     neg;
   logic [32:0]              mag_full;
   logic [31:0]              mag;
   logic [47:0]              prod;
   logic [TERM_W-1:0]        shifted;
   logic signed [TERM_W:0]   term_in;

   // sign and magnitude so the shift truncates toward zero; |operand| < 2^32
   assign neg      = operand[32];
   assign mag_full = neg ? (33'd0 - operand) : operand;
   assign mag      = mag_full[31:0];
   assign prod     = mag * gain;
   assign shifted  = prod[47:GAIN_FRAC_BITS];
   assign term_in  = neg ? -$signed({1'b0, shifted}) : $signed({1'b0, shifted});

   always_ff @(posedge clock) begin
      if (load) begin
         term_ff <= term_in;
      end
   end

endmodule

>>> rtl/qppd_mix.sv
module qppd_mix #(
   parameter int GAIN_FRAC_BITS = 12,
   parameter int DUTY_MAX       = 255
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              update,
   input  logic signed [48-GAIN_FRAC_BITS:0] p_term,
   input  logic signed [48-GAIN_FRAC_BITS:0] i_term,
   input  logic signed [48-GAIN_FRAC_BITS:0] d_term,
   output logic [7:0]                        duty_ff,
   output logic                              fwd_ff
);

   localparam int          TERM_W   = 48 - GAIN_FRAC_BITS;
   localparam int          SUM_W    = TERM_W + 3;
   localparam logic [7:0]  DUTY_CAP = (DUTY_MAX > 255) ? 8'd255 : 8'(DUTY_MAX);

   logic signed [SUM_W-1:0] sum;
   logic [SUM_W-1:0]        mag;
   logic [7:0]              duty_in;
   logic                    fwd_in;

   assign sum     = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);
   assign fwd_in  = ~sum[SUM_W-1];
   assign mag     = sum[SUM_W-1] ? (SUM_W'(0) - sum) : sum;
   assign duty_in = (mag > SUM_W'(DUTY_CAP)) ? DUTY_CAP : mag[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff <= '0;
         fwd_ff  <= 1'b1;
      end else if (update) begin
         duty_ff <= duty_in;
         fwd_ff  <= fwd_in;
      end
   end

endmodule

>>> verif/tb_quadrature_pid_position_drive.sv
`timescale 1ns / 1ps

module tb_quadrature_pid_position_drive;
   import qppd_pkg::*;

   // request code that the block must treat as a no-op
   localparam logic [1:0] REQ_SPARE = 2'd3;

   localparam int GAIN_FRAC    = 12;
   localparam int DUTY_CAP     = 255;
   localparam int DRAIN_CYCLES = 8;       // three-stage pipe plus margin
   localparam int LONG_HOLD    = 400;     // response hold-off, far beyond the pipe depth
   localparam int RUN_LIMIT    = 1000000;

   // Pairs such that every (previous, new) combination appears once from 00
   localparam logic [1:0] DEBRUIJN_PAIRS [16] = '{
      2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd1,
      2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0
   };

   typedef struct packed {
      logic [1:0] kind;
      logic       chan_a;
      logic       chan_b;
   } drive_req_type;

   typedef struct packed {
      logic signed [31:0] position;
      logic [7:0]         duty;
      logic               forward;
   } drive_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // [0] chan_a, [1] chan_b, rest zero
   logic [1:0]  req_tuser = 2'd0;    // [1:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;           // [31:0] position, [39:32] duty, [40] forward
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_addr = 2'd0;
   logic [31:0] csr_wdata = 32'd0;

   quadrature_pid_position_drive uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // Shadow of the drive: settings, encoder and PID state
   logic signed [31:0] goal_cfg   = GOAL_RST;
   logic [15:0]        kp_cfg     = KP_RST;
   logic [15:0]        ki_cfg     = KI_RST;
   logic [15:0]        kd_cfg     = KD_RST;
   logic [1:0]         enc_pair   = 2'b00;
   logic signed [31:0] pos_count  = 32'sd0;
   logic signed [31:0] integ_acc  = 32'sd0;
   logic signed [31:0] last_err   = 32'sd0;
   logic [7:0]         duty_latch = 8'd0;
   logic               fwd_latch  = 1'b1;

   // Stimulus and scoreboard
   drive_req_type pending_reqs[$];
   drive_rsp_type expected_drive[$];
   drive_req_type next_req;
   drive_rsp_type want;
   logic [1:0] gen_pair = 2'b00;   // encoder pair the stimulus has last produced
   logic       idle_on = 1'b1;
   logic       hold_request = 1'b0;
   int         hold_left = 0;
   int         send_gap = 0;
   int         recv_gap = 0;
   int         transfers_in = 0;
   int         ticks_in = 0;
   int         results_seen = 0;
   int         settings_used = 0;
   int         fault_count = 0;
   int         cycle_count = 0;

   task automatic report_fault(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fault_count++;
   endtask

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
      if (v < longint'(32'sh8000_0000)) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // gain * x / 2^GAIN_FRAC with truncation toward zero
   function automatic longint scaled_term(logic [15:0] gain, longint x);
      longint mag;
      longint prod;
      mag  = (x < 0) ? -x : x;
      prod = (mag * longint'({48'd0, gain})) >>> GAIN_FRAC;
      return (x < 0) ? -prod : prod;
   endfunction

   // +1 / -1 / 0 for a move from one A/B pair to the next
   function automatic int quad_delta(logic [1:0] prev, logic [1:0] now);
      case ({prev, now})
         4'b0001, 4'b0111, 4'b1110, 4'b1000: return 1;
         4'b0010, 4'b1011, 4'b1101, 4'b0100: return -1;
         default:                            return 0;
      endcase
   endfunction

   // Advance the shadow by one request and return the response it should give
   function automatic drive_rsp_type predict_drive(logic [1:0] kind, logic a, logic b);
      drive_rsp_type      r;
      logic signed [31:0] err;
      longint             total;
      longint             mag;
      case (kind)
         REQ_ENC: begin
            pos_count = pos_count + quad_delta(enc_pair, {a, b});
            enc_pair  = {a, b};
         end
         REQ_TICK: begin
            err       = clamp32(longint'(goal_cfg) - longint'(pos_count));
            integ_acc = clamp32(longint'(integ_acc) + longint'(err));
            total     = scaled_term(kp_cfg, longint'(err))
                      + scaled_term(ki_cfg, longint'(integ_acc))
                      + scaled_term(kd_cfg, longint'(err) - longint'(last_err));
            fwd_latch  = (total >= 0);
            mag        = (total >= 0) ? total : -total;
            duty_latch = (mag > DUTY_CAP) ? 8'(DUTY_CAP) : mag[7:0];
            last_err   = err;
         end
         REQ_ZERO: pos_count = 32'sd0;
         default: ;
      endcase
      r.position = pos_count;
      r.duty     = duty_latch;
      r.forward  = fwd_latch;
      return r;
   endfunction

   // Mostly short gaps, now and then a long one; none while idling is off
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] pick_gain(int typical_max);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'd0;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom_range(0, typical_max));
   endfunction

   function automatic logic signed [31:0] pick_goal();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'sh8000_0000;
      if (r == 1) return 32'sh7FFF_FFFF;
      if (r == 2) return $urandom;
      return int'($urandom_range(0, 6000)) - 3000;
   endfunction

   function automatic logic [1:0] next_gray(logic [1:0] p, logic up);
      case (p)
         2'b00:   return up ? 2'b01 : 2'b10;
         2'b01:   return up ? 2'b11 : 2'b00;
         2'b11:   return up ? 2'b10 : 2'b01;
         default: return up ? 2'b00 : 2'b11;
      endcase
   endfunction

   // Write every register back to back; the block must be idle here.
   // Gain words carry junk above bit 15, which the block must drop.
   task automatic apply_config(logic signed [31:0] goal, logic [15:0] kp,
                               logic [15:0] ki, logic [15:0] kd);
      logic [1:0]  idx;
      logic [31:0] word;
      for (int r = 0; r < 4; r++) begin
         idx = r[1:0];
         case (idx)
            CSR_GOAL: word = goal;
            CSR_KP:   word = {16'($urandom), kp};
            CSR_KI:   word = {16'($urandom), ki};
            default:  word = {16'($urandom), kd};
         endcase
         @(posedge clock);
         csr_wr_en <= 1'b1;
         csr_addr  <= idx;
         csr_wdata <= word;
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
      goal_cfg = goal;
      kp_cfg   = kp;
      ki_cfg   = ki;
      kd_cfg   = kd;
      settings_used++;
   endtask

   task automatic push_req(logic [1:0] kind, logic [1:0] pair);
      drive_req_type q;
      q.kind   = kind;
      q.chan_a = pair[1];
      q.chan_b = pair[0];
      pending_reqs.push_back(q);
      if (kind == REQ_ENC) gen_pair = pair;
   endtask

   // A clean quadrature run in one direction
   task automatic push_walk(logic up, int steps);
      for (int i = 0; i < steps; i++) push_req(REQ_ENC, next_gray(gen_pair, up));
   endtask

   // Mostly clean runs, with ticks, zero and spare requests sprinkled in and some noise on top
   task automatic push_mix(int n);
      int start;
      int r;
      start = pending_reqs.size();
      while (pending_reqs.size() - start < n) begin
         r = $urandom_range(0, 99);
         if (r < 60)      push_walk(1'($urandom_range(0, 1)), $urandom_range(1, 24));
         else if (r < 72) push_req(REQ_ENC, 2'($urandom));
         else if (r < 90) push_req(REQ_TICK, 2'($urandom));
         else if (r < 95) push_req(REQ_ZERO, 2'($urandom));
         else             push_req(REQ_SPARE, 2'($urandom));
      end
   endtask

   // Wait until every request is sent and every response is back, then let the pipe settle
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_drive.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Driver: predict on each accepted transfer, then offer the next request
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_drive.push_back(predict_drive(req_tuser, req_tdata[0], req_tdata[1]));
            transfers_in++;
            if (req_tuser == REQ_TICK) ticks_in++;
         end
         // hold the offer while the block stalls it
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               next_req = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {6'd0, next_req.chan_b, next_req.chan_a};
               req_tuser  <= next_req.kind;
               send_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each response with the oldest prediction, and throttle
   // the response channel, including the one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_drive.size() == 0) begin
               report_fault($sformatf("response %0d arrived with nothing outstanding",
                                      results_seen));
            end else begin
               want = expected_drive.pop_front();
               if (rsp_tdata[31:0] !== want.position)
                  report_fault($sformatf("response %0d position: expected %0d, got %0d",
                     results_seen, want.position, $signed(rsp_tdata[31:0])));
               if (rsp_tdata[39:32] !== want.duty)
                  report_fault($sformatf("response %0d duty: expected %0d, got %0d",
                     results_seen, want.duty, rsp_tdata[39:32]));
               if (rsp_tdata[40] !== want.forward)
                  report_fault($sformatf("response %0d forward: expected %0b, got %0b",
                     results_seen, want.forward, rsp_tdata[40]));
            end
            results_seen++;
         end
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_gap = pick_gap();
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("[%0t] run limit of %0d cycles reached", $realtime, RUN_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: walk the pair sequence that visits every (old, new)
      // transition of the encoder table once, starting from the reset pair,
      // then a tick, a zero request, the unused request code and another tick
      foreach (DEBRUIJN_PAIRS[i]) push_req(REQ_ENC, DEBRUIJN_PAIRS[i]);
      push_req(REQ_TICK, 2'b00);
      push_req(REQ_ZERO, 2'b11);
      push_req(REQ_SPARE, 2'b10);
      push_req(REQ_TICK, 2'b01);
      wait_drained();

      // Error clamped at the negative end, integral saturating, full gains
      apply_config(32'sh8000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      repeat (3) push_req(REQ_TICK, 2'b00);
      push_walk(1'b1, 3);
      push_req(REQ_TICK, 2'b11);
      push_req(REQ_ZERO, 2'b00);
      push_req(REQ_TICK, 2'b10);
      wait_drained();

      // Swing to the positive end: derivative sees a full 33-bit difference
      apply_config(32'sh7FFF_FFFF, 16'd0, 16'hFFFF, 16'd0);
      push_walk(1'b0, 5);
      repeat (3) push_req(REQ_TICK, 2'b01);
      wait_drained();

      // All gains zero: duty collapses to zero, direction forward
      apply_config(32'sd0, 16'd0, 16'd0, 16'd0);
      repeat (2) push_req(REQ_TICK, 2'b10);
      push_walk(1'b1, 2);
      push_req(REQ_TICK, 2'b00);
      wait_drained();

      // Random phases, each under its own register setting
      for (int ph = 0; ph < 8; ph++) begin
         apply_config(pick_goal(), pick_gain(16384), pick_gain(2048), pick_gain(32768));
         idle_on = (ph != 3);
         if (ph == 1) begin
            // stall the response side so the pipe fills and req_tready drops
            @(negedge clock);
            hold_request = 1'b1;
         end
         push_mix(225);
         wait_drained();
      end

      $display("Sent %0d requests (%0d control ticks) under %0d register settings.",
               transfers_in, ticks_in, settings_used);
      $display("Compared %0d responses, with random gaps and a %0d-cycle response stall.",
               results_seen, LONG_HOLD);
      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/qppd_pkg.sv
rtl/qppd_state.sv
rtl/qppd_gain.sv
rtl/qppd_mix.sv
rtl/quadrature_pid_position_drive.sv
verif/tb_quadrature_pid_position_drive.sv
